/* src/skt_pkg.sv */
// shared types and constants for the sorted key table
package skt_pkg;

  localparam int DEPTH_DEFAULT     = 256;
  localparam int KEY_BYTES_DEFAULT = 6;
  localparam int KEY_FIELD_W       = 48;
  localparam int STATUS_W          = 3;
  localparam int INDEX_W           = 8;
  localparam int COUNT_OUT_W       = 9;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_FULL      = 3'd2,
    ST_REM_PLAIN = 3'd3,
    ST_REM_SEED  = 3'd4,
    ST_MISSING   = 3'd5
  } status_t;

  // request kinds carried on the input tuser
  localparam logic CMD_FIND_INSERT = 1'b0;
  localparam logic CMD_REMOVE      = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_MID,
    OP_COMPARE,
    OP_PTR_INIT,
    OP_READ_MOVE,
    OP_WRITE_MOVE,
    OP_WRITE_NEW,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic hit;
    logic full;
    logic move_done;
    logic is_remove;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INSERT,
    S_FINISH
  } fsm_state_t;

endpackage

/* src/sorted_key_table_insert_remove_core.sv */
// top level of the sorted key table with find-or-insert and remove
//
// keeps up to DEPTH entries (key plus seeding flag) sorted by unsigned key.
// input channel s_axis: one request per handshake; tuser selects find-or-insert
// or remove, tdata carries key and seeding flag.
// output channel m_axis: exactly one result per request, in request order.
// a request binary-searches the entry memory, each probe an address and then
// registered read data, with ceil(log2(count+1)) probes at most.
// an insert then moves every entry at and above the insert position up one slot and
// a remove moves every later entry down one slot, each moved entry a read and then a
// write through the memory; an insert adds one write for the new entry.
// only one request is in work at a time; the next one is taken in the cycle after
// the result is written to the output register, even if the receiver has not taken it.
// if the receiver stalls, the result holds and a following request waits
// just before its own result is written.
// reset clears the entry count and the output valid and holds the input not ready;
// entry memory is not cleared, since only entries below the count are ever read.
module sorted_key_table_insert_remove_core #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEFAULT,
  parameter int KEY_BYTES = skt_pkg::KEY_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // key [47:0], seeding [48], zero pad [55:49]
  input  logic        s_axis_tuser,   // cmd [0]: find or insert, remove
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status [2:0], found [3], index [11:4],
                                      // entry_count [20:12], zero pad [23:21]
);

  skt_pkg::dp_cmd_t  cmd;
  skt_pkg::dp_stat_t stat;

  logic [skt_pkg::STATUS_W-1:0]    status;
  logic                            found;
  logic [skt_pkg::INDEX_W-1:0]     index;
  logic [skt_pkg::COUNT_OUT_W-1:0] entry_count;

  // sequencer: probe loop, shift loop, result hand-off
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry memory, search bounds and the output register
  skt_dp #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (s_axis_tuser),
    .in_key          (s_axis_tdata[47:0]),
    .in_seeding      (s_axis_tdata[48]),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_status      (status),
    .out_found       (found),
    .out_index       (index),
    .out_entry_count (entry_count)
  );

  assign m_axis_tdata = {3'b000, entry_count, index, found, status};

endmodule

/* src/skt_ctrl.sv */
// controller state machine: search, shift and result sequencing
module skt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  skt_pkg::dp_stat_t stat,
  output skt_pkg::dp_cmd_t  cmd
);

  skt_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = skt_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      skt_pkg::S_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op     = skt_pkg::OP_LOAD;
          state_next = skt_pkg::S_SEARCH_RD;
        end
      end
      skt_pkg::S_SEARCH_RD: begin
        if (stat.search_done) begin
          state_next = skt_pkg::S_DECIDE;
        end else begin
          cmd.op     = skt_pkg::OP_READ_MID;
          state_next = skt_pkg::S_SEARCH_CMP;
        end
      end
      skt_pkg::S_SEARCH_CMP: begin
        cmd.op     = skt_pkg::OP_COMPARE;
        state_next = skt_pkg::S_SEARCH_RD;
      end
      skt_pkg::S_DECIDE: begin
        if (stat.is_remove) begin
          if (stat.hit) begin
            cmd.op     = skt_pkg::OP_PTR_INIT;
            state_next = skt_pkg::S_MOVE_RD;
          end else begin
            state_next = skt_pkg::S_FINISH;
          end
        end else if (stat.hit || stat.full) begin
          state_next = skt_pkg::S_FINISH;
        end else begin
          cmd.op     = skt_pkg::OP_PTR_INIT;
          state_next = skt_pkg::S_MOVE_RD;
        end
      end
      skt_pkg::S_MOVE_RD: begin
        if (stat.move_done) begin
          state_next = stat.is_remove ? skt_pkg::S_FINISH : skt_pkg::S_INSERT;
        end else begin
          cmd.op     = skt_pkg::OP_READ_MOVE;
          state_next = skt_pkg::S_MOVE_WR;
        end
      end
      skt_pkg::S_MOVE_WR: begin
        cmd.op     = skt_pkg::OP_WRITE_MOVE;
        state_next = skt_pkg::S_MOVE_RD;
      end
      skt_pkg::S_INSERT: begin
        cmd.op     = skt_pkg::OP_WRITE_NEW;
        state_next = skt_pkg::S_FINISH;
      end
      skt_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.op     = skt_pkg::OP_FINISH;
          state_next = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/skt_dp.sv */
// datapath: entry memory, search bounds, shift pointer and result register
module skt_dp #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEFAULT,
  parameter int KEY_BYTES = skt_pkg::KEY_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  skt_pkg::dp_cmd_t                cmd,
  output skt_pkg::dp_stat_t               stat,
  input  logic                            in_cmd,
  input  logic [skt_pkg::KEY_FIELD_W-1:0] in_key,
  input  logic                            in_seeding,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [skt_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_found,
  output logic [skt_pkg::INDEX_W-1:0]     out_index,
  output logic [skt_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int KEY_W = (KEY_BYTES * 8 < skt_pkg::KEY_FIELD_W) ?
                         KEY_BYTES * 8 : skt_pkg::KEY_FIELD_W;
  localparam int MW    = KEY_W + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // key in the upper bits, seeding flag in bit 0
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata;

  logic [KEY_W-1:0] key_q;
  logic             seed_q;
  logic             cmd_q;
  logic [CW-1:0]    lo, hi, ptr, count;
  logic             eq, hit_seed;

  logic [CW-1:0]    mid, count_next;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [MW-1:0]    wr_data;
  logic             wr_en;
  logic             is_rem, hit, full;
  logic [KEY_W-1:0] rkey;

  assign is_rem = (cmd_q == skt_pkg::CMD_REMOVE);
  assign mid    = lo + ((hi - lo) >> 1);
  assign rkey   = rdata[MW-1:1];
  // eq tracks the last entry that pulled hi down, which is the lower bound
  assign hit    = eq && (lo < count);
  assign full   = (count == CW'(DEPTH));

  assign stat.search_done = (lo == hi);
  assign stat.hit         = hit;
  assign stat.full        = full;
  assign stat.move_done   = is_rem ? (CW'(ptr + 1'b1) == count) : (ptr == lo);
  assign stat.is_remove   = is_rem;
  assign stat.out_busy    = out_valid && !out_ready;

  always_comb begin
    rd_addr = mid[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rdata;
    case (cmd.op)
      skt_pkg::OP_READ_MOVE: begin
        rd_addr = is_rem ? AW'(ptr + 1'b1) : AW'(ptr - 1'b1);
      end
      skt_pkg::OP_WRITE_MOVE: begin
        wr_en = 1'b1;
      end
      skt_pkg::OP_WRITE_NEW: begin
        wr_en   = 1'b1;
        wr_addr = lo[AW-1:0];
        wr_data = {key_q, seed_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (is_rem) begin
      if (hit) count_next = count - 1'b1;
    end else if (!hit && !full) begin
      count_next = count + 1'b1;
    end
  end

  // search and shift registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      skt_pkg::OP_LOAD: begin
        key_q    <= in_key[KEY_W-1:0];
        seed_q   <= in_seeding;
        cmd_q    <= in_cmd;
        lo       <= '0;
        hi       <= count;
        eq       <= 1'b0;
        hit_seed <= 1'b0;
      end
      skt_pkg::OP_COMPARE: begin
        if (rkey < key_q) begin
          lo <= mid + 1'b1;
        end else begin
          hi       <= mid;
          eq       <= (rkey == key_q);
          hit_seed <= rdata[0];
        end
      end
      skt_pkg::OP_PTR_INIT: begin
        ptr <= is_rem ? lo : count;
      end
      skt_pkg::OP_WRITE_MOVE: begin
        ptr <= is_rem ? CW'(ptr + 1'b1) : CW'(ptr - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (cmd.op == skt_pkg::OP_FINISH) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == skt_pkg::OP_FINISH) begin
      out_found       <= hit;
      out_entry_count <= skt_pkg::COUNT_OUT_W'(count_next);
      out_index       <= '0;
      if (is_rem) begin
        if (hit) begin
          out_status <= hit_seed ? skt_pkg::ST_REM_SEED : skt_pkg::ST_REM_PLAIN;
          out_index  <= skt_pkg::INDEX_W'(lo);
        end else begin
          out_status <= skt_pkg::ST_MISSING;
        end
      end else if (hit) begin
        out_status <= skt_pkg::ST_FOUND;
        out_index  <= skt_pkg::INDEX_W'(lo);
      end else if (full) begin
        out_status <= skt_pkg::ST_FULL;
      end else begin
        out_status <= skt_pkg::ST_INSERTED;
        out_index  <= skt_pkg::INDEX_W'(lo);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == skt_pkg::OP_COMPARE) |-> (lo <= hi) && (hi <= count))
    else $error("search bounds out of order");

  a_count_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != skt_pkg::OP_FINISH) |=> $stable(count))
    else $error("count changed outside finish");

  a_insert_ptr: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == skt_pkg::OP_WRITE_MOVE && !is_rem) |-> (ptr > lo))
    else $error("insert shift ran below insert position");

endmodule
